>>> design/mcmq_pkg.sv
package mcmq_pkg;

  // Widths of the transaction fields; these are fixed by the interface.
  localparam int unsigned ChanW = 3;
  localparam int unsigned MsgW  = 64;
  localparam int unsigned MaskW = 8;

  typedef enum logic {
    CMD_SEND    = 1'b0,
    CMD_DELIVER = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             command;
    logic [ChanW-1:0] channel;
    logic [MsgW-1:0]  message;
    logic [MaskW-1:0] channel_mask;
    logic             sink_ready;
  } in_item_t;

  typedef struct packed {
    logic             sent;
    logic [ChanW-1:0] sent_channel;
    logic [MsgW-1:0]  sent_message;
    logic             queued;
    logic             dropped;
    logic [MaskW-1:0] pending_mask;
  } out_item_t;

  // Decision made in the accept cycle. It travels with the transaction
  // until the message store's read data is available.
  typedef struct packed {
    logic             sent;
    logic             from_mem;
    logic [ChanW-1:0] sent_channel;
    logic             queued;
    logic             dropped;
    logic [MaskW-1:0] pending_mask;
  } decision_t;

endpackage

>>> design/mcmq_if.sv
interface mcmq_in_if;
  logic                valid;
  logic                ready;
  mcmq_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mcmq_out_if;
  logic                valid;
  logic                ready;
  mcmq_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/mcmq_msg_ram.sv
module mcmq_msg_ram #(
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [mcmq_pkg::MsgW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [mcmq_pkg::MsgW-1:0] rdata_o
);

  logic [mcmq_pkg::MsgW-1:0] mem [DEPTH];
  logic [mcmq_pkg::MsgW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mcmq_ptr_ctrl.sv
module mcmq_ptr_ctrl #(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned QUEUE_DEPTH = 64,
  localparam int unsigned AW = (CHANNELS * QUEUE_DEPTH > 1) ?
                               $clog2(CHANNELS * QUEUE_DEPTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  mcmq_pkg::in_item_t        item_i,
  output mcmq_pkg::decision_t       dec_o,
  output logic                      wr_en_o,
  output logic [AW-1:0]             wr_addr_o,
  output logic                      rd_en_o,
  output logic [AW-1:0]             rd_addr_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Each pointer is a slot index plus a lap bit; equal indexes mean empty
  // when the lap bits agree and full when they differ.
  logic [PW-1:0] wr_idx_q [CHANNELS];
  logic [PW-1:0] wr_idx_d [CHANNELS];
  logic [PW-1:0] rd_idx_q [CHANNELS];
  logic [PW-1:0] rd_idx_d [CHANNELS];
  logic [CHANNELS-1:0] wr_lap_q, wr_lap_d, rd_lap_q, rd_lap_d;
  logic [CHANNELS-1:0] empty, full;

  logic          is_send, ch_ok, bypass, enqueue, drop, found, dequeue;
  logic [CW-1:0] send_ch, hit_ch;
  logic [mcmq_pkg::MaskW-1:0] pend;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_flags
    assign empty[c] = (wr_idx_q[c] == rd_idx_q[c]) && (wr_lap_q[c] == rd_lap_q[c]);
    assign full[c]  = (wr_idx_q[c] == rd_idx_q[c]) && (wr_lap_q[c] != rd_lap_q[c]);
  end

  assign is_send = (item_i.command == mcmq_pkg::CMD_SEND);
  assign ch_ok   = ({1'b0, item_i.channel} < 4'(CHANNELS));
  assign send_ch = CW'(item_i.channel);

  // Lowest-numbered masked channel that holds a message.
  always_comb begin
    found  = 1'b0;
    hit_ch = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (item_i.channel_mask[c] && !empty[c]) begin
        found  = 1'b1;
        hit_ch = CW'(c);
      end
    end
  end

  assign bypass  = is_send && ch_ok && empty[send_ch] && item_i.sink_ready;
  assign enqueue = is_send && ch_ok && !bypass && !full[send_ch];
  assign drop    = is_send && ch_ok && full[send_ch];
  assign dequeue = !is_send && found && item_i.sink_ready;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      wr_idx_d[c] = wr_idx_q[c];
      wr_lap_d[c] = wr_lap_q[c];
      rd_idx_d[c] = rd_idx_q[c];
      rd_lap_d[c] = rd_lap_q[c];
      if (enqueue && (send_ch == CW'(c))) begin
        if (wr_idx_q[c] == PW'(QUEUE_DEPTH - 1)) begin
          wr_idx_d[c] = '0;
          wr_lap_d[c] = ~wr_lap_q[c];
        end else begin
          wr_idx_d[c] = wr_idx_q[c] + PW'(1);
        end
      end
      if (dequeue && (hit_ch == CW'(c))) begin
        if (rd_idx_q[c] == PW'(QUEUE_DEPTH - 1)) begin
          rd_idx_d[c] = '0;
          rd_lap_d[c] = ~rd_lap_q[c];
        end else begin
          rd_idx_d[c] = rd_idx_q[c] + PW'(1);
        end
      end
    end
  end

  // Occupancy after this transaction, restricted to the mask.
  always_comb begin
    pend = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      pend[c] = item_i.channel_mask[c] &&
                !((wr_idx_d[c] == rd_idx_d[c]) && (wr_lap_d[c] == rd_lap_d[c]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wr_idx_q[c] <= '0;
        rd_idx_q[c] <= '0;
      end
      wr_lap_q <= '0;
      rd_lap_q <= '0;
    end else if (accept_i) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wr_idx_q[c] <= wr_idx_d[c];
        rd_idx_q[c] <= rd_idx_d[c];
      end
      wr_lap_q <= wr_lap_d;
      rd_lap_q <= rd_lap_d;
    end
  end

  assign wr_en_o   = accept_i && enqueue;
  assign wr_addr_o = AW'(send_ch) * AW'(QUEUE_DEPTH) + AW'(wr_idx_q[send_ch]);
  assign rd_en_o   = accept_i && dequeue;
  assign rd_addr_o = AW'(hit_ch) * AW'(QUEUE_DEPTH) + AW'(rd_idx_q[hit_ch]);

  always_comb begin
    dec_o              = '0;
    dec_o.sent         = bypass || dequeue;
    dec_o.from_mem     = dequeue;
    dec_o.queued       = enqueue;
    dec_o.dropped      = drop;
    dec_o.pending_mask = pend;
    if (bypass) begin
      dec_o.sent_channel = item_i.channel;
    end else if (dequeue) begin
      dec_o.sent_channel = mcmq_pkg::ChanW'(hit_ch);
    end
  end

endmodule

>>> design/multi_channel_mailbox_tx_queue_core.sv
// Per-channel mailbox transmit queue. Each of CHANNELS channels owns a FIFO
// of QUEUE_DEPTH 64-bit messages, all held in one shared message store with
// a synchronous read. A send transaction goes straight to the sink
// when its channel is empty and the sink is ready, is queued otherwise, and is
// dropped (and flagged) when the queue is full; a send naming a channel at or
// above CHANNELS is ignored. A deliver transaction pops the head of the
// lowest-numbered masked channel that holds a message, provided the sink is
// ready. Every result carries the masked set of non-empty queues after the
// transaction. The block takes one transaction per cycle while the single
// in-flight stage is empty or can move on, also while a result waits at the
// output; a result moves from the in-flight stage to the output register. The
// pointer decision is made in the accept cycle, the store read is registered
// at the accepting edge, and the result register loads when the in-flight
// stage moves on. The pointers reset to empty at once, so no clearing pass is
// needed; store entries are only read after being written.
module multi_channel_mailbox_tx_queue_core #(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mcmq_in_if.sink           in_i,
  mcmq_out_if.source        out_o
);

  localparam int unsigned DEPTH = CHANNELS * QUEUE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                      accept;
  logic                      s1_valid_q;
  mcmq_pkg::decision_t       s1_dec_q;
  logic [mcmq_pkg::MsgW-1:0] s1_msg_q;
  logic                      out_valid_q;
  mcmq_pkg::out_item_t       out_item_q, out_item_d;
  logic                      s1_move;

  mcmq_pkg::decision_t       dec;
  logic                      wr_en, rd_en;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [mcmq_pkg::MsgW-1:0] rdata;

  // The in-flight stage drains into the output register whenever that
  // register is empty or being taken; a new transaction may enter behind it.
  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign accept     = in_i.valid && in_i.ready;

  mcmq_ptr_ctrl #(
    .CHANNELS    (CHANNELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ptr_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_i.data),
    .dec_o     (dec),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr)
  );

  // The read data register only loads on a dequeue, so it holds steady while
  // the transaction that read it waits in the in-flight stage.
  mcmq_msg_ram #(
    .DEPTH (DEPTH)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (in_i.data.message),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_dec_q <= dec;
      s1_msg_q <= in_i.data.message;
    end
  end

  // Result assembly: a popped message comes from the store, a bypassed one
  // from the transaction itself, and nothing sent reports a zero payload.
  always_comb begin
    out_item_d              = '0;
    out_item_d.sent         = s1_dec_q.sent;
    out_item_d.sent_channel = s1_dec_q.sent_channel;
    out_item_d.queued       = s1_dec_q.queued;
    out_item_d.dropped      = s1_dec_q.dropped;
    out_item_d.pending_mask = s1_dec_q.pending_mask;
    if (s1_dec_q.from_mem) begin
      out_item_d.sent_message = rdata;
    end else if (s1_dec_q.sent) begin
      out_item_d.sent_message = s1_msg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

endmodule
